/* design/fqr_pkg.sv */
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types and constants for the fault qualifier with recovery.
// ----------------------------------------------------------------------------
package fqr_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int TIME_BITS_DEF   = 32;

  localparam int LIMIT_BITS    = 12;
  localparam int QUAL_BITS     = 32;
  localparam int COUNT_BITS    = 16;
  localparam int TALLY_BITS    = 8;
  localparam int MODE_BITS     = 6;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [TALLY_BITS-1:0] TALLY_MAX = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE            = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_RECOVER   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_RECOVER   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAULT_QUALIFY   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECOVER_QUALIFY = 3'd6;

  // mode_control bit positions
  localparam int MODE_SRC_ADC  = 0;
  localparam int MODE_LIM_LO   = 1;
  localparam int MODE_LIM_HI   = 2;
  localparam int MODE_COUNT    = 3;
  localparam int MODE_TRIG_LVL = 4;
  localparam int MODE_REC_LVL  = 5;

  // Limit modes
  localparam logic [1:0] LIM_OVER   = 2'd0;
  localparam logic [1:0] LIM_UNDER  = 2'd1;
  localparam logic [1:0] LIM_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_CLEAR = 2'd0,
    VERDICT_FAULT = 2'd1,
    VERDICT_UNDET = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FAULT   = 2'd1,
    EV_RECOVER = 2'd2
  } event_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode_control;
    logic [LIMIT_BITS-1:0] upper_limit;
    logic [LIMIT_BITS-1:0] upper_recover;
    logic [LIMIT_BITS-1:0] lower_limit;
    logic [LIMIT_BITS-1:0] lower_recover;
    logic [QUAL_BITS-1:0]  fault_qualify;
    logic [QUAL_BITS-1:0]  recover_qualify;
  } cfg_t;

endpackage

/* design/fqr_if.sv */
// ----------------------------------------------------------------------------
// fqr_item_if / fqr_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fqr_item_if #(
  parameter int SAMPLE_BITS = fqr_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = fqr_pkg::TIME_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_value;
  logic                   bit_level;
  logic [TIME_BITS-1:0]   time_now;
  logic                   fault_enable;
  logic                   recover_enable;
  logic                   recover_lock;

  modport source (
    output valid, sample_value, bit_level, time_now, fault_enable,
           recover_enable, recover_lock,
    input  ready
  );
  modport sink (
    input  valid, sample_value, bit_level, time_now, fault_enable,
           recover_enable, recover_lock,
    output ready
  );
endinterface

interface fqr_result_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      event_res;
  logic                            fault_active;
  logic [fqr_pkg::TALLY_BITS-1:0]  fault_tally;
  logic [1:0]                      raw_verdict;

  modport source (
    output valid, event_res, fault_active, fault_tally, raw_verdict,
    input  ready
  );
  modport sink (
    input  valid, event_res, fault_active, fault_tally, raw_verdict,
    output ready
  );
endinterface

/* design/fqr_verdict.sv */
// ----------------------------------------------------------------------------
// fqr_verdict
// Raw verdict from the digital level or from the sample thresholds.
// ----------------------------------------------------------------------------
module fqr_verdict #(
  parameter int SAMPLE_BITS = fqr_pkg::SAMPLE_BITS_DEF
) (
  input  fqr_pkg::cfg_t     cfg,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  logic              bit_level,
  output fqr_pkg::verdict_t verdict
);

  // Thresholds are 12-bit registers; only the bits both sides share count.
  localparam int CMP_BITS = (SAMPLE_BITS < fqr_pkg::LIMIT_BITS) ?
                            SAMPLE_BITS : fqr_pkg::LIMIT_BITS;

  logic [CMP_BITS-1:0] s, ul, ur, ll, lr;
  logic [1:0]          lim;

  assign s   = sample_value[CMP_BITS-1:0];
  assign ul  = cfg.upper_limit[CMP_BITS-1:0];
  assign ur  = cfg.upper_recover[CMP_BITS-1:0];
  assign ll  = cfg.lower_limit[CMP_BITS-1:0];
  assign lr  = cfg.lower_recover[CMP_BITS-1:0];
  assign lim = cfg.mode_control[fqr_pkg::MODE_LIM_HI:fqr_pkg::MODE_LIM_LO];

  always_comb begin
    verdict = fqr_pkg::VERDICT_UNDET;
    if (!cfg.mode_control[fqr_pkg::MODE_SRC_ADC]) begin
      if (bit_level == cfg.mode_control[fqr_pkg::MODE_TRIG_LVL]) begin
        verdict = fqr_pkg::VERDICT_FAULT;
      end else if (bit_level == cfg.mode_control[fqr_pkg::MODE_REC_LVL]) begin
        verdict = fqr_pkg::VERDICT_CLEAR;
      end
    end else begin
      case (lim)
        fqr_pkg::LIM_OVER: begin
          if (s >= ul)      verdict = fqr_pkg::VERDICT_FAULT;
          else if (s < ur)  verdict = fqr_pkg::VERDICT_CLEAR;
        end
        fqr_pkg::LIM_UNDER: begin
          if (s <= ll)      verdict = fqr_pkg::VERDICT_FAULT;
          else if (s > lr)  verdict = fqr_pkg::VERDICT_CLEAR;
        end
        fqr_pkg::LIM_WINDOW: begin
          if (s >= ll && s <= ul)     verdict = fqr_pkg::VERDICT_FAULT;
          else if (s < lr || s > ur)  verdict = fqr_pkg::VERDICT_CLEAR;
        end
        default: verdict = fqr_pkg::VERDICT_UNDET;
      endcase
    end
  end

endmodule

/* design/fault_qualifier_with_recovery_core.sv */
// ----------------------------------------------------------------------------
// fault_qualifier_with_recovery_core
// Debounce with hysteresis: timer or up/down count qualification of a fault
// condition and of its recovery, with a saturating fault tally.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  item      in         valid/ready    sample_value, bit_level, time_now,
//                                      fault_enable, recover_enable, recover_lock
//  result    out        valid/ready    event_res, fault_active, fault_tally,
//                                      raw_verdict
//  cfg       in         cfg_we         cfg_index, cfg_data (write only)
//
//  One item per cycle sustained while results are taken; an item passes the
//  input register, then the result register. The state updates as an item
//  moves into the result register. A stalled result holds both stages; ready
//  falls only when both are full and the result is not taken. Synchronous
//  reset clears state and restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module fault_qualifier_with_recovery_core #(
  parameter int SAMPLE_BITS = fqr_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = fqr_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  fqr_item_if.sink                          item,
  fqr_result_if.source                      result,
  input  logic                              cfg_we,
  input  logic [fqr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fqr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int QB = fqr_pkg::QUAL_BITS;
  localparam int CB = fqr_pkg::COUNT_BITS;

  // Configuration
  fqr_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_control    <= '0;
      cfg.upper_limit     <= '1;
      cfg.upper_recover   <= '1;
      cfg.lower_limit     <= '0;
      cfg.lower_recover   <= '0;
      cfg.fault_qualify   <= '0;
      cfg.recover_qualify <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fqr_pkg::REG_MODE:
          cfg.mode_control <= cfg_data[fqr_pkg::MODE_BITS-1:0];
        fqr_pkg::REG_UPPER_LIMIT:
          cfg.upper_limit <= cfg_data[fqr_pkg::LIMIT_BITS-1:0];
        fqr_pkg::REG_UPPER_RECOVER:
          cfg.upper_recover <= cfg_data[fqr_pkg::LIMIT_BITS-1:0];
        fqr_pkg::REG_LOWER_LIMIT:
          cfg.lower_limit <= cfg_data[fqr_pkg::LIMIT_BITS-1:0];
        fqr_pkg::REG_LOWER_RECOVER:
          cfg.lower_recover <= cfg_data[fqr_pkg::LIMIT_BITS-1:0];
        fqr_pkg::REG_FAULT_QUALIFY:
          cfg.fault_qualify <= cfg_data[QB-1:0];
        fqr_pkg::REG_RECOVER_QUALIFY:
          cfg.recover_qualify <= cfg_data[QB-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   s1_level;
  logic [TIME_BITS-1:0]   s1_now;
  logic                   s1_fen;
  logic                   s1_ren;
  logic                   s1_lock;

  logic out_free;
  logic advance;

  assign out_free   = !result.valid || result.ready;
  assign advance    = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_sample <= item.sample_value;
      s1_level  <= item.bit_level;
      s1_now    <= item.time_now;
      s1_fen    <= item.fault_enable;
      s1_ren    <= item.recover_enable;
      s1_lock   <= item.recover_lock;
    end
  end

  // Verdict
  fqr_pkg::verdict_t verdict;

  fqr_verdict #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_verdict (
    .cfg          (cfg),
    .sample_value (s1_sample),
    .bit_level    (s1_level),
    .verdict      (verdict)
  );

  // Qualifier state
  logic                          fault_latched, fault_latched_next;
  logic                          fault_timing, fault_timing_next;
  logic [TIME_BITS-1:0]          fault_start, fault_start_next;
  logic                          recover_timing, recover_timing_next;
  logic [TIME_BITS-1:0]          recover_start, recover_start_next;
  logic [CB-1:0]                 qualify_count, qualify_count_next;
  logic [fqr_pkg::TALLY_BITS-1:0] tally_store, tally_store_next;
  fqr_pkg::event_t               ev_next;

  logic [TIME_BITS-1:0] fault_elapsed, recover_elapsed;
  logic                 fault_mid;
  logic                 recover_live;
  logic                 tally_inc;
  logic [CB-1:0]        fault_count, recover_count;

  assign fault_count   = cfg.fault_qualify[CB-1:0];
  assign recover_count = cfg.recover_qualify[CB-1:0];

  always_comb begin
    fault_latched_next  = fault_latched;
    fault_timing_next   = fault_timing;
    fault_start_next    = fault_start;
    recover_timing_next = recover_timing;
    recover_start_next  = recover_start;
    qualify_count_next  = qualify_count;
    ev_next             = fqr_pkg::EV_NONE;
    tally_inc           = 1'b0;
    fault_elapsed       = '0;
    recover_elapsed     = '0;
    fault_mid           = fault_latched;
    recover_live        = 1'b0;

    if (!cfg.mode_control[fqr_pkg::MODE_COUNT]) begin
      // Timer basis
      if (verdict == fqr_pkg::VERDICT_FAULT && !fault_latched && s1_fen) begin
        fault_timing_next = 1'b1;
        if (!fault_timing) fault_start_next = s1_now;
      end else begin
        fault_timing_next = 1'b0;
      end
      fault_elapsed = s1_now - fault_start_next;
      if (fault_timing_next && QB'(fault_elapsed) > cfg.fault_qualify) begin
        fault_mid         = 1'b1;
        fault_timing_next = 1'b0;
        ev_next           = fqr_pkg::EV_FAULT;
        tally_inc         = 1'b1;
      end
      fault_latched_next = fault_mid;

      recover_live = fault_mid && s1_ren && !s1_lock;
      if (recover_live && verdict == fqr_pkg::VERDICT_CLEAR) begin
        recover_timing_next = 1'b1;
        if (!recover_timing) recover_start_next = s1_now;
      end else begin
        recover_timing_next = 1'b0;
      end
      recover_elapsed = s1_now - recover_start_next;
      if (recover_timing_next && QB'(recover_elapsed) > cfg.recover_qualify) begin
        fault_latched_next  = 1'b0;
        recover_timing_next = 1'b0;
        ev_next             = fqr_pkg::EV_RECOVER;
      end
    end else begin
      // Count basis; an undetermined verdict counts down like clear
      if (verdict != fqr_pkg::VERDICT_FAULT) begin
        if (qualify_count != '0) qualify_count_next = qualify_count - 1'b1;
      end else if (qualify_count < fault_count) begin
        qualify_count_next = qualify_count + 1'b1;
      end
      if (qualify_count_next >= fault_count && s1_fen) begin
        fault_latched_next = 1'b1;
        ev_next            = fqr_pkg::EV_FAULT;
        tally_inc          = 1'b1;
      end else if (qualify_count_next <= recover_count && s1_ren && !s1_lock) begin
        fault_latched_next = 1'b0;
        ev_next            = fqr_pkg::EV_RECOVER;
      end
    end

    tally_store_next = tally_store;
    if (tally_inc && tally_store != fqr_pkg::TALLY_MAX) begin
      tally_store_next = tally_store + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_latched  <= 1'b0;
      fault_timing   <= 1'b0;
      recover_timing <= 1'b0;
      qualify_count  <= '0;
      tally_store    <= '0;
    end else if (advance) begin
      fault_latched  <= fault_latched_next;
      fault_timing   <= fault_timing_next;
      recover_timing <= recover_timing_next;
      qualify_count  <= qualify_count_next;
      tally_store    <= tally_store_next;
    end
  end

  // Start times are only read while their timer runs
  always_ff @(posedge clk) begin
    if (advance) begin
      fault_start   <= fault_start_next;
      recover_start <= recover_start_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.event_res    <= ev_next;
      result.fault_active <= fault_latched_next;
      result.fault_tally  <= tally_store_next;
      result.raw_verdict  <= verdict;
    end
  end

  // Assertions
  a_active_tracks_state: assert property (
    @(posedge clk) disable iff (rst)
    advance |=> (result.fault_active == fault_latched)
  ) else $error("result fault_active differs from latched state");

  a_fault_event_active: assert property (
    @(posedge clk) disable iff (rst)
    (result.valid && result.event_res == fqr_pkg::EV_FAULT) |-> result.fault_active
  ) else $error("fault event without active fault");

  a_recover_event_clear: assert property (
    @(posedge clk) disable iff (rst)
    (result.valid && result.event_res == fqr_pkg::EV_RECOVER) |-> !result.fault_active
  ) else $error("recover event with fault still active");

  a_tally_step: assert property (
    @(posedge clk) disable iff (rst)
    (advance && ev_next == fqr_pkg::EV_FAULT && tally_store != fqr_pkg::TALLY_MAX)
      |=> (tally_store == $past(tally_store) + 1'b1)
  ) else $error("fault tally did not advance on fault event");

endmodule

/* sim/tb_fault_qualifier_with_recovery_core.sv */
// ----------------------------------------------------------------------------
// tb_fault_qualifier_with_recovery_core
// Self-checking bench for the fault qualifier. A driver feeds readings from
// a queue and predicts each result at the moment of transfer. A monitor
// compares every result transfer against the oldest prediction. Directed
// cases come first, then randomised settings with runs of held conditions.
// Random stalls on both sides, one long receiver hold-off, and a watchdog
// on cycles without any transfer or settings write.
// ----------------------------------------------------------------------------
module tb_fault_qualifier_with_recovery_core;

  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          LONG_HOLD      = 400;
  localparam int          RANDOM_PHASES  = 60;
  localparam logic [1:0]  LIM_DEAD       = 2'd3;

  typedef struct {
    logic [11:0] sample;
    logic        lvl;
    logic [31:0] stamp;
    logic        fen;
    logic        ren;
    logic        lock;
  } reading_t;

  typedef struct {
    fqr_pkg::event_t   ev;
    logic              active;
    logic [7:0]        tally;
    fqr_pkg::verdict_t verdict;
  } outcome_t;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [fqr_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [fqr_pkg::CFG_DATA_BITS-1:0] cfg_data;

  fqr_item_if   item_ch ();
  fqr_result_if res_ch ();

  fault_qualifier_with_recovery_core dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // settings copy
  logic [5:0]  mode_reg;
  logic [11:0] ul_reg, ur_reg, ll_reg, lr_reg;
  logic [31:0] fq_reg, rq_reg;

  // qualifier state copy
  logic        latched;
  logic        f_timing, r_timing;
  logic [31:0] f_start, r_start;
  logic [15:0] q_count;
  logic [7:0]  tally;

  reading_t pending_items[$];
  outcome_t expected_results[$];
  reading_t next_reading, taken;
  outcome_t want;

  int  in_flight = 0;
  int  send_gap, recv_stall, hold_left;
  int  hold_requests = 0, holds_served;
  bit  idle_on = 1'b1;
  int  idle_cycles;
  int  fail_count = 0;
  int  items_accepted = 0, results_checked = 0;
  int  faults_seen = 0, recoveries_seen = 0, settings_used = 0;
  logic [31:0] tick;

  function automatic int idle_pick();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic fqr_pkg::verdict_t judge(logic [11:0] s, logic lvl);
    fqr_pkg::verdict_t v;
    v = fqr_pkg::VERDICT_UNDET;
    if (!mode_reg[fqr_pkg::MODE_SRC_ADC]) begin
      if (lvl == mode_reg[fqr_pkg::MODE_TRIG_LVL]) v = fqr_pkg::VERDICT_FAULT;
      else if (lvl == mode_reg[fqr_pkg::MODE_REC_LVL]) v = fqr_pkg::VERDICT_CLEAR;
    end else begin
      case (mode_reg[fqr_pkg::MODE_LIM_HI:fqr_pkg::MODE_LIM_LO])
        fqr_pkg::LIM_OVER: begin
          if (s >= ul_reg) v = fqr_pkg::VERDICT_FAULT;
          else if (s < ur_reg) v = fqr_pkg::VERDICT_CLEAR;
        end
        fqr_pkg::LIM_UNDER: begin
          if (s <= ll_reg) v = fqr_pkg::VERDICT_FAULT;
          else if (s > lr_reg) v = fqr_pkg::VERDICT_CLEAR;
        end
        fqr_pkg::LIM_WINDOW: begin
          if (s >= ll_reg && s <= ul_reg) v = fqr_pkg::VERDICT_FAULT;
          else if (s < lr_reg || s > ur_reg) v = fqr_pkg::VERDICT_CLEAR;
        end
        default: v = fqr_pkg::VERDICT_UNDET;
      endcase
    end
    return v;
  endfunction

  function automatic outcome_t qualify_step(reading_t r);
    outcome_t          o;
    fqr_pkg::verdict_t v;
    logic [31:0]       held;
    v = judge(r.sample, r.lvl);
    o.ev = fqr_pkg::EV_NONE;
    if (!mode_reg[fqr_pkg::MODE_COUNT]) begin
      if (v == fqr_pkg::VERDICT_FAULT && !latched && r.fen) begin
        if (!f_timing) begin
          f_timing = 1'b1;
          f_start  = r.stamp;
        end
      end else begin
        f_timing = 1'b0;
      end
      held = r.stamp - f_start;
      if (f_timing && held > fq_reg) begin
        latched  = 1'b1;
        f_timing = 1'b0;
        o.ev     = fqr_pkg::EV_FAULT;
        if (tally != fqr_pkg::TALLY_MAX) tally = tally + 8'd1;
      end
      if (latched && r.ren && !r.lock) begin
        if (v == fqr_pkg::VERDICT_CLEAR) begin
          if (!r_timing) begin
            r_timing = 1'b1;
            r_start  = r.stamp;
          end
        end else begin
          r_timing = 1'b0;
        end
        held = r.stamp - r_start;
        if (r_timing && held > rq_reg) begin
          latched  = 1'b0;
          r_timing = 1'b0;
          o.ev     = fqr_pkg::EV_RECOVER;
        end
      end else begin
        r_timing = 1'b0;
      end
    end else begin
      // undetermined counts down just as clear does
      if (v != fqr_pkg::VERDICT_FAULT) begin
        if (q_count != 16'd0) q_count = q_count - 16'd1;
      end else if (q_count < fq_reg[15:0]) begin
        q_count = q_count + 16'd1;
      end
      if (q_count >= fq_reg[15:0] && r.fen) begin
        latched = 1'b1;
        o.ev    = fqr_pkg::EV_FAULT;
        if (tally != fqr_pkg::TALLY_MAX) tally = tally + 8'd1;
      end else if (q_count <= rq_reg[15:0] && r.ren && !r.lock) begin
        latched = 1'b0;
        o.ev    = fqr_pkg::EV_RECOVER;
      end
    end
    o.active  = latched;
    o.tally   = tally;
    o.verdict = v;
    return o;
  endfunction

  task automatic write_reg(input logic [fqr_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      fqr_pkg::REG_MODE:            mode_reg = data[5:0];
      fqr_pkg::REG_UPPER_LIMIT:     ul_reg   = data[11:0];
      fqr_pkg::REG_UPPER_RECOVER:   ur_reg   = data[11:0];
      fqr_pkg::REG_LOWER_LIMIT:     ll_reg   = data[11:0];
      fqr_pkg::REG_LOWER_RECOVER:   lr_reg   = data[11:0];
      fqr_pkg::REG_FAULT_QUALIFY:   fq_reg   = data;
      fqr_pkg::REG_RECOVER_QUALIFY: rq_reg   = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_reading(input logic [11:0] s, input logic l, input logic [31:0] t,
                               input logic fe, input logic re, input logic lk);
    reading_t r;
    r.sample = s;
    r.lvl    = l;
    r.stamp  = t;
    r.fen    = fe;
    r.ren    = re;
    r.lock   = lk;
    pending_items.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_flight != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [31:0] qual_pick();
    logic [31:0] q;
    case ($urandom_range(0, 9))
      0:       q = 32'd0;
      1:       q = 32'hFFFF_FFFF;
      2:       q = $urandom();
      default: q = 32'($urandom_range(1, 12));
    endcase
    return q;
  endfunction

  task automatic random_setup();
    int          pick;
    logic [11:0] hi, lo;
    write_reg(fqr_pkg::REG_MODE, 32'($urandom_range(0, 63)));
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      write_reg(fqr_pkg::REG_UPPER_LIMIT,   32'($urandom_range(0, 4095)));
      write_reg(fqr_pkg::REG_UPPER_RECOVER, 32'($urandom_range(0, 4095)));
      write_reg(fqr_pkg::REG_LOWER_LIMIT,   32'($urandom_range(0, 4095)));
      write_reg(fqr_pkg::REG_LOWER_RECOVER, 32'($urandom_range(0, 4095)));
    end else if (pick == 2) begin
      write_reg(fqr_pkg::REG_UPPER_LIMIT,   32'($urandom_range(0, 1) * 4095));
      write_reg(fqr_pkg::REG_UPPER_RECOVER, 32'($urandom_range(0, 1) * 4095));
      write_reg(fqr_pkg::REG_LOWER_LIMIT,   32'($urandom_range(0, 1) * 4095));
      write_reg(fqr_pkg::REG_LOWER_RECOVER, 32'($urandom_range(0, 1) * 4095));
    end else begin
      // hysteresis bands the usual way round
      hi = 12'($urandom_range(1500, 4095));
      lo = 12'($urandom_range(0, 1500));
      write_reg(fqr_pkg::REG_UPPER_LIMIT,   32'(hi));
      write_reg(fqr_pkg::REG_UPPER_RECOVER, 32'(hi - 12'($urandom_range(0, 200))));
      write_reg(fqr_pkg::REG_LOWER_LIMIT,   32'(lo));
      write_reg(fqr_pkg::REG_LOWER_RECOVER, 32'(lo + 12'($urandom_range(0, 200))));
    end
    write_reg(fqr_pkg::REG_FAULT_QUALIFY,   qual_pick());
    write_reg(fqr_pkg::REG_RECOVER_QUALIFY, qual_pick());
    if ($urandom_range(0, 7) == 0) tick = 32'hFFFF_FFF0 - 32'($urandom_range(0, 20));
    settings_used++;
  endtask

  // runs of readings near a base value so conditions hold long enough to qualify
  task automatic random_burst(input int n);
    int          left, run, x;
    logic [11:0] base, s;
    logic        lvl;
    left = n;
    run  = 0;
    base = 12'd0;
    lvl  = 1'b0;
    while (left > 0) begin
      if (run == 0) begin
        run = $urandom_range(1, 30);
        case ($urandom_range(0, 6))
          0:       base = ul_reg;
          1:       base = ur_reg;
          2:       base = ll_reg;
          3:       base = lr_reg;
          4:       base = 12'd0;
          5:       base = 12'hFFF;
          default: base = 12'($urandom());
        endcase
        lvl = 1'($urandom());
      end
      if ($urandom_range(0, 7) == 0) begin
        s = 12'($urandom());
      end else begin
        x = int'(base) + $urandom_range(0, 4) - 2;
        if (x < 0) x = 0;
        if (x > 4095) x = 4095;
        s = 12'(x);
      end
      if ($urandom_range(0, 9) == 0) lvl = ~lvl;
      case ($urandom_range(0, 19))
        0:       tick = $urandom();
        1, 2:    tick = tick + 32'($urandom_range(4, 50));
        default: tick = tick + 32'($urandom_range(0, 3));
      endcase
      queue_reading(s, lvl, tick, $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0,
                    $urandom_range(0, 6) == 0);
      run--;
      left--;
    end
  endtask

  // driver: prediction is taken from the bus at the moment of transfer
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        taken.sample = item_ch.sample_value;
        taken.lvl    = item_ch.bit_level;
        taken.stamp  = item_ch.time_now;
        taken.fen    = item_ch.fault_enable;
        taken.ren    = item_ch.recover_enable;
        taken.lock   = item_ch.recover_lock;
        expected_results.push_back(qualify_step(taken));
        items_accepted++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap > 0) begin
          item_ch.valid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
          next_reading = pending_items.pop_front();
          in_flight++;
          item_ch.valid          <= 1'b1;
          item_ch.sample_value   <= next_reading.sample;
          item_ch.bit_level      <= next_reading.lvl;
          item_ch.time_now       <= next_reading.stamp;
          item_ch.fault_enable   <= next_reading.fen;
          item_ch.recover_enable <= next_reading.ren;
          item_ch.recover_lock   <= next_reading.lock;
          send_gap               <= idle_pick();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_stall   <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: event_res=%0d", res_ch.event_res);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          in_flight--;
          results_checked++;
          if (res_ch.event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, res_ch.event_res);
            fail_count++;
          end
          if (res_ch.fault_active !== want.active) begin
            $error("fault_active: expected %0d, got %0d", want.active, res_ch.fault_active);
            fail_count++;
          end
          if (res_ch.fault_tally !== want.tally) begin
            $error("fault_tally: expected %0d, got %0d", want.tally, res_ch.fault_tally);
            fail_count++;
          end
          if (res_ch.raw_verdict !== want.verdict) begin
            $error("raw_verdict: expected %0d, got %0d", want.verdict, res_ch.raw_verdict);
            fail_count++;
          end
          if (want.ev == fqr_pkg::EV_FAULT) faults_seen++;
          if (want.ev == fqr_pkg::EV_RECOVER) recoveries_seen++;
        end
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
        res_ch.ready <= 1'b0;
        holds_served <= hold_requests;
        hold_left    <= LONG_HOLD;
      end else if (recv_stall > 0) begin
        res_ch.ready <= 1'b0;
        recv_stall   <= recv_stall - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        recv_stall   <= idle_pick();
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = fqr_pkg::REG_MODE;
    cfg_data  = '0;
    mode_reg = '0;
    ul_reg   = 12'hFFF;
    ur_reg   = 12'hFFF;
    ll_reg   = '0;
    lr_reg   = '0;
    fq_reg   = '0;
    rq_reg   = '0;
    latched  = 1'b0;
    f_timing = 1'b0;
    r_timing = 1'b0;
    f_start  = '0;
    r_start  = '0;
    q_count  = '0;
    tally    = '0;
    tick     = 32'd100;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: equal trigger and recover levels, timer started at time zero
    queue_reading(12'd0, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b0, 32'd1, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b1, 32'd2, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // level recovery, first blocked by the lock
    write_reg(fqr_pkg::REG_MODE, 32'(1 << fqr_pkg::MODE_TRIG_LVL));
    queue_reading(12'd0, 1'b0, 32'd3, 1'b1, 1'b1, 1'b1);
    queue_reading(12'd0, 1'b0, 32'd4, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b0, 32'd5, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // over limit at full scale, qualified across the time wrap
    write_reg(fqr_pkg::REG_MODE, 32'({fqr_pkg::LIM_OVER, 1'b1}));
    write_reg(fqr_pkg::REG_UPPER_RECOVER, 32'd0);
    queue_reading(12'hFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    queue_reading(12'hFFF, 1'b1, 32'd0, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b0, 32'd1, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // unused limit mode, then under limit
    write_reg(fqr_pkg::REG_MODE, 32'({LIM_DEAD, 1'b1}));
    queue_reading(12'd0, 1'b0, 32'd2, 1'b1, 1'b1, 1'b0);
    queue_reading(12'hFFF, 1'b1, 32'd3, 1'b1, 1'b1, 1'b0);
    wait_drained();
    write_reg(fqr_pkg::REG_MODE, 32'({fqr_pkg::LIM_UNDER, 1'b1}));
    queue_reading(12'd0, 1'b0, 32'd4, 1'b1, 1'b1, 1'b0);
    queue_reading(12'hFFF, 1'b0, 32'd5, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // window with recover bands either side
    write_reg(fqr_pkg::REG_MODE, 32'({fqr_pkg::LIM_WINDOW, 1'b1}));
    write_reg(fqr_pkg::REG_LOWER_LIMIT, 32'd100);
    write_reg(fqr_pkg::REG_UPPER_LIMIT, 32'd200);
    write_reg(fqr_pkg::REG_LOWER_RECOVER, 32'd50);
    write_reg(fqr_pkg::REG_UPPER_RECOVER, 32'd250);
    queue_reading(12'd150, 1'b0, 32'd10, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd20, 1'b0, 32'd11, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd60, 1'b0, 32'd12, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd300, 1'b0, 32'd13, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // count basis: repeated fault events, then undetermined counts back down
    write_reg(fqr_pkg::REG_MODE,
              32'((1 << fqr_pkg::MODE_COUNT) | (1 << fqr_pkg::MODE_TRIG_LVL)));
    write_reg(fqr_pkg::REG_FAULT_QUALIFY, 32'd2);
    write_reg(fqr_pkg::REG_RECOVER_QUALIFY, 32'd0);
    queue_reading(12'd0, 1'b1, 32'd20, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b1, 32'd21, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b1, 32'd22, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b1, 32'd23, 1'b0, 1'b1, 1'b0);
    wait_drained();
    write_reg(fqr_pkg::REG_MODE, 32'((1 << fqr_pkg::MODE_COUNT) |
                                     (1 << fqr_pkg::MODE_TRIG_LVL) |
                                     (1 << fqr_pkg::MODE_REC_LVL)));
    queue_reading(12'd0, 1'b0, 32'd24, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b0, 32'd25, 1'b1, 1'b1, 1'b0);
    queue_reading(12'd0, 1'b0, 32'd26, 1'b1, 1'b1, 1'b0);
    wait_drained();

    tick = 32'd1000;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph % 10 != 9);
      random_setup();
      if (ph == 5) begin
        // long receiver hold-off while readings keep coming
        random_burst(80);
        hold_requests++;
      end else begin
        random_burst($urandom_range(20, 42));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d readings over %0d random settings plus directed cases;",
             items_accepted, settings_used);
    $display("%0d results checked, %0d fault and %0d recovery events, tally at %0d.",
             results_checked, faults_seen, recoveries_seen, tally);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
